@@ src/triangle_cotan_weights_top_defines.svh @@
// Assertion macros used by the top RTL file of the cotangent weight block.
`ifndef TRIANGLE_COTAN_WEIGHTS_TOP_DEFINES_SVH
`define TRIANGLE_COTAN_WEIGHTS_TOP_DEFINES_SVH

// Plain property, checked on every clock edge outside reset.
`define COTW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication, checked on every clock edge outside reset.
`define COTW_ASSERT_IMPL(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

`endif

@@ src/cotw_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cotw_pkg
// Widths, types and constants of the cotangent weight pipeline.
// ----------------------------------------------------------------------------
package cotw_pkg;

  localparam int COORD_BITS  = 24;
  localparam int WEIGHT_BITS = 32;
  localparam int EPS_W       = 32;
  localparam int NCORNER     = 3;

  localparam int DIFF_W   = COORD_BITS + 1;
  localparam int PROD_W   = 2 * DIFF_W;
  localparam int CROSS_W  = PROD_W + 1;
  localparam int DOT_W    = PROD_W + 2;
  localparam int DMAG_W   = PROD_W;
  localparam int CMAG_W   = PROD_W;
  localparam int SQ_LO_W  = CMAG_W / 2;
  localparam int SQ_HI_W  = CMAG_W - SQ_LO_W;
  localparam int HH_W     = 2 * SQ_HI_W;
  localparam int HL_W     = SQ_HI_W + SQ_LO_W;
  localparam int LL_W     = 2 * SQ_LO_W;
  localparam int SQ_W     = 2 * CMAG_W;
  localparam int S_W      = SQ_W + 2;
  localparam int ROOT_W   = S_W / 2;
  localparam int EPS_SH   = 16;
  localparam int EPSQ_W   = EPS_W + EPS_SH;
  localparam int Q_W      = ((ROOT_W > EPSQ_W) ? ROOT_W : EPSQ_W) + 1;
  localparam int NUM_SH   = 15;
  localparam int NUM_W    = DMAG_W + NUM_SH;
  localparam int QUO_W    = WEIGHT_BITS + 1;
  localparam int NUMP_W   = (NUM_W > QUO_W) ? NUM_W : QUO_W + 1;
  localparam int REM_W    = Q_W + 1;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef coord_t [2:0]                 point_t;
  typedef point_t [NCORNER-1:0]         tri_t;
  typedef logic signed [DIFF_W-1:0]     diff_t;
  typedef logic signed [PROD_W-1:0]     prod_t;

  typedef struct packed {
    logic              neg;
    logic [DMAG_W-1:0] mag;
  } dot_t;

  typedef dot_t [NCORNER-1:0] dot3_t;

  // Result of one divider lane, handed to the output stage.
  typedef struct packed {
    logic             valid;
    logic             neg;
    logic             dzero;
    logic             qzero;
    logic             ovf;
    logic [QUO_W-1:0] quo;
  } div_res_t;

endpackage
`default_nettype wire

@@ src/cotw_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cotw_front
// Edge vectors, dot products and squared cross-product length, six stages.
// ----------------------------------------------------------------------------
module cotw_front import cotw_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  tri_t             tri_i,
  output logic             valid_o,
  output logic [S_W-1:0]   s_o,
  output dot3_t            dots_o
);

  logic valid_q [6];

  diff_t u_d [NCORNER][3], v_d [NCORNER][3];
  diff_t u_q [NCORNER][3], v_q [NCORNER][3];
  prod_t dp_d [NCORNER][3], dp_q [NCORNER][3];
  prod_t cp_d [6], cp_q [6];
  dot3_t dots3_d, dots3_q, dots4_q, dots5_q, dots6_q;
  logic [CMAG_W-1:0] cm_d [3], cm_q [3];
  logic [HH_W-1:0] hh_d [3], hh_q [3];
  logic [HL_W-1:0] hl_d [3], hl_q [3];
  logic [LL_W-1:0] ll_d [3], ll_q [3];
  logic [SQ_W-1:0] sq_d [3], sq_q [3];
  logic [S_W-1:0]  s_d, s_q;

  // stage 1: edge vectors per corner
  always_comb begin
    for (int k = 0; k < NCORNER; k++) begin
      for (int i = 0; i < 3; i++) begin
        u_d[k][i] = DIFF_W'($signed(tri_i[(k+1)%NCORNER][i])) - DIFF_W'($signed(tri_i[k][i]));
        v_d[k][i] = DIFF_W'($signed(tri_i[(k+2)%NCORNER][i])) - DIFF_W'($signed(tri_i[k][i]));
      end
    end
  end

  // stage 2: products; the cross product is the same at every corner
  always_comb begin
    for (int k = 0; k < NCORNER; k++) begin
      for (int i = 0; i < 3; i++) begin
        dp_d[k][i] = PROD_W'(u_q[k][i]) * PROD_W'(v_q[k][i]);
      end
    end
    cp_d[0] = PROD_W'(u_q[0][1]) * PROD_W'(v_q[0][2]);
    cp_d[1] = PROD_W'(u_q[0][2]) * PROD_W'(v_q[0][1]);
    cp_d[2] = PROD_W'(u_q[0][2]) * PROD_W'(v_q[0][0]);
    cp_d[3] = PROD_W'(u_q[0][0]) * PROD_W'(v_q[0][2]);
    cp_d[4] = PROD_W'(u_q[0][0]) * PROD_W'(v_q[0][1]);
    cp_d[5] = PROD_W'(u_q[0][1]) * PROD_W'(v_q[0][0]);
  end

  // stage 3: sums, then sign and magnitude
  always_comb begin
    logic signed [DOT_W-1:0]   dsum;
    logic signed [DOT_W-1:0]   dneg;
    logic signed [CROSS_W-1:0] c;
    logic signed [CROSS_W-1:0] cneg;
    for (int k = 0; k < NCORNER; k++) begin
      dsum = DOT_W'(dp_q[k][0]) + DOT_W'(dp_q[k][1]) + DOT_W'(dp_q[k][2]);
      dneg = -dsum;
      dots3_d[k].neg = dsum[DOT_W-1];
      dots3_d[k].mag = dsum[DOT_W-1] ? dneg[DMAG_W-1:0] : dsum[DMAG_W-1:0];
    end
    for (int j = 0; j < 3; j++) begin
      c    = CROSS_W'(cp_q[2*j]) - CROSS_W'(cp_q[2*j+1]);
      cneg = -c;
      cm_d[j] = c[CROSS_W-1] ? cneg[CMAG_W-1:0] : c[CMAG_W-1:0];
    end
  end

  // stage 4: partial squares; stage 5: combine; stage 6: sum
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      hh_d[j] = HH_W'(cm_q[j][CMAG_W-1:SQ_LO_W]) * HH_W'(cm_q[j][CMAG_W-1:SQ_LO_W]);
      hl_d[j] = HL_W'(cm_q[j][CMAG_W-1:SQ_LO_W]) * HL_W'(cm_q[j][SQ_LO_W-1:0]);
      ll_d[j] = LL_W'(cm_q[j][SQ_LO_W-1:0]) * LL_W'(cm_q[j][SQ_LO_W-1:0]);
      sq_d[j] = (SQ_W'(hh_q[j]) << (2 * SQ_LO_W)) + (SQ_W'(hl_q[j]) << (SQ_LO_W + 1))
              + SQ_W'(ll_q[j]);
    end
    s_d = S_W'(sq_q[0]) + S_W'(sq_q[1]) + S_W'(sq_q[2]);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      u_q     <= u_d;
      v_q     <= v_d;
      dp_q    <= dp_d;
      cp_q    <= cp_d;
      dots3_q <= dots3_d;
      cm_q    <= cm_d;
      dots4_q <= dots3_q;
      hh_q    <= hh_d;
      hl_q    <= hl_d;
      ll_q    <= ll_d;
      dots5_q <= dots4_q;
      sq_q    <= sq_d;
      dots6_q <= dots5_q;
      s_q     <= s_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 6; i++) valid_q[i] <= 1'b0;
    end else if (en_i) begin
      valid_q[0] <= valid_i;
      for (int i = 1; i < 6; i++) valid_q[i] <= valid_q[i-1];
    end
  end

  assign valid_o = valid_q[5];
  assign s_o     = s_q;
  assign dots_o  = dots6_q;

endmodule
`default_nettype wire

@@ src/cotw_sqrt.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cotw_sqrt
// Pipelined integer square root, one result bit per stage, rounded down.
// ----------------------------------------------------------------------------
module cotw_sqrt import cotw_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [S_W-1:0]    s_i,
  input  dot3_t             side_i,
  output logic              valid_o,
  output logic [ROOT_W-1:0] root_o,
  output dot3_t             side_o
);

  logic           valid_q [ROOT_W];
  logic [S_W-1:0] num_q   [ROOT_W];
  logic [S_W-1:0] res_q   [ROOT_W];
  dot3_t          side_q  [ROOT_W];

  for (genvar g = 0; g < ROOT_W; g++) begin : g_stage
    localparam logic [S_W-1:0] Bit = S_W'(1) << (S_W - 2 - 2 * g);
    logic [S_W-1:0] num_in, res_in, t, num_d, res_d;
    dot3_t          side_in;
    logic           v_in;

    if (g == 0) begin : g_first
      assign num_in  = s_i;
      assign res_in  = '0;
      assign side_in = side_i;
      assign v_in    = valid_i;
    end else begin : g_next
      assign num_in  = num_q[g-1];
      assign res_in  = res_q[g-1];
      assign side_in = side_q[g-1];
      assign v_in    = valid_q[g-1];
    end

    always_comb begin
      t = res_in + Bit;
      if (num_in >= t) begin
        num_d = num_in - t;
        res_d = (res_in >> 1) + Bit;
      end else begin
        num_d = num_in;
        res_d = res_in >> 1;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        num_q[g]  <= num_d;
        res_q[g]  <= res_d;
        side_q[g] <= side_in;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[g] <= 1'b0;
      end else if (en_i) begin
        valid_q[g] <= v_in;
      end
    end
  end

  assign valid_o = valid_q[ROOT_W-1];
  assign root_o  = res_q[ROOT_W-1][ROOT_W-1:0];
  assign side_o  = side_q[ROOT_W-1];

endmodule
`default_nettype wire

@@ src/cotw_div.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cotw_div
// Pipelined restoring divider for one corner: |dot| * 2^15 / denominator.
// ----------------------------------------------------------------------------
module cotw_div import cotw_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  dot_t              dot_i,
  input  logic [Q_W-1:0]    q_i,
  input  logic              qzero_i,
  output div_res_t          res_o
);

  localparam int NSTG = QUO_W + 1;

  typedef struct packed {
    logic             neg;
    logic             dzero;
    logic             qzero;
    logic             ovf;
    logic [Q_W-1:0]   q;
    logic [REM_W-1:0] rem;
    logic [QUO_W-1:0] numlow;
    logic [QUO_W-1:0] quo;
  } div_st_t;

  logic    valid_q [NSTG];
  div_st_t st_q    [NSTG];

  // stage 0: top part of the dividend decides overflow of the quotient
  div_st_t          st0_d;
  logic [NUMP_W-1:0] numpad;
  always_comb begin
    numpad       = NUMP_W'({dot_i.mag, NUM_SH'(0)});
    st0_d.neg    = dot_i.neg;
    st0_d.dzero  = (dot_i.mag == '0);
    st0_d.qzero  = qzero_i;
    st0_d.q      = q_i;
    st0_d.rem    = REM_W'(numpad >> QUO_W);
    st0_d.ovf    = (REM_W'(numpad >> QUO_W) >= REM_W'(q_i));
    st0_d.numlow = numpad[QUO_W-1:0];
    st0_d.quo    = '0;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) st_q[0] <= st0_d;
  end

  for (genvar g = 1; g < NSTG; g++) begin : g_stage
    div_st_t          st_d;
    logic [REM_W-1:0] r2;
    logic             qbit;

    always_comb begin
      st_d = st_q[g-1];
      r2   = {st_q[g-1].rem[REM_W-2:0], st_q[g-1].numlow[QUO_W-1]};
      qbit = (r2 >= REM_W'(st_q[g-1].q));
      st_d.rem    = qbit ? r2 - REM_W'(st_q[g-1].q) : r2;
      st_d.numlow = st_q[g-1].numlow << 1;
      st_d.quo    = {st_q[g-1].quo[QUO_W-2:0], qbit};
    end

    always_ff @(posedge clk_i) begin
      if (en_i) st_q[g] <= st_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NSTG; i++) valid_q[i] <= 1'b0;
    end else if (en_i) begin
      valid_q[0] <= valid_i;
      for (int i = 1; i < NSTG; i++) valid_q[i] <= valid_q[i-1];
    end
  end

  assign res_o.valid = valid_q[NSTG-1];
  assign res_o.neg   = st_q[NSTG-1].neg;
  assign res_o.dzero = st_q[NSTG-1].dzero;
  assign res_o.qzero = st_q[NSTG-1].qzero;
  assign res_o.ovf   = st_q[NSTG-1].ovf;
  assign res_o.quo   = st_q[NSTG-1].quo;

endmodule
`default_nettype wire

@@ src/triangle_cotan_weights_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// triangle_cotan_weights_top
// Cotangent weights of the three corners of one triangle, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries the nine Q8.16 vertex
//   coordinates of one triangle. Output channel (out_valid_o/out_ready_i)
//   returns the three Q16.16 weights and the saturation flag.
//   cfg_we_i/cfg_wdata_i write denom_eps; write it only while the block is
//   empty.
//   Throughput: one triangle per cycle while the output is not stalled.
//   Pipeline: 6 front stages, 51 square-root stages, one denominator stage,
//   34 divider stages, one output register.
//   The whole pipeline advances together: when the output register holds a
//   transaction that is not taken, every stage holds and in_ready_o drops.
//   Empty stages are not squeezed out.
//   Reset clears all valid bits and sets denom_eps to zero; the block is
//   ready in the first cycle after reset.
// ----------------------------------------------------------------------------
`include "triangle_cotan_weights_top_defines.svh"

module triangle_cotan_weights_top import cotw_pkg::*; (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [EPS_W-1:0]              cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [COORD_BITS-1:0]  corner_a_x_i,
  input  logic signed [COORD_BITS-1:0]  corner_a_y_i,
  input  logic signed [COORD_BITS-1:0]  corner_a_z_i,
  input  logic signed [COORD_BITS-1:0]  corner_b_x_i,
  input  logic signed [COORD_BITS-1:0]  corner_b_y_i,
  input  logic signed [COORD_BITS-1:0]  corner_b_z_i,
  input  logic signed [COORD_BITS-1:0]  corner_c_x_i,
  input  logic signed [COORD_BITS-1:0]  corner_c_y_i,
  input  logic signed [COORD_BITS-1:0]  corner_c_z_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [WEIGHT_BITS-1:0] weight_a_o,
  output logic signed [WEIGHT_BITS-1:0] weight_b_o,
  output logic signed [WEIGHT_BITS-1:0] weight_c_o,
  output logic                          saturated_o
);

  localparam logic [QUO_W-1:0] LimPos = QUO_W'((QUO_W'(1) << (WEIGHT_BITS - 1)) - 1);
  localparam logic [QUO_W-1:0] LimNeg = QUO_W'(1) << (WEIGHT_BITS - 1);
  localparam logic [WEIGHT_BITS-1:0] WMax = LimPos[WEIGHT_BITS-1:0];
  localparam logic [WEIGHT_BITS-1:0] WMin = LimNeg[WEIGHT_BITS-1:0];

  logic             en;
  logic [EPS_W-1:0] eps_q;
  tri_t             tri_in;

  logic              fr_valid;
  logic [S_W-1:0]    fr_s;
  dot3_t             fr_dots;
  logic              sq_valid;
  logic [ROOT_W-1:0] sq_root;
  dot3_t             sq_dots;

  logic           qs_valid_q;
  logic [Q_W-1:0] qs_q_q;
  logic           qs_qzero_q;
  dot3_t          qs_dots_q;
  logic [Q_W-1:0] qs_q_d;

  div_res_t dv [NCORNER];

  logic                   out_valid_q, sat_q, sat_d;
  logic [WEIGHT_BITS-1:0] w_q [NCORNER];
  logic [WEIGHT_BITS-1:0] w_d [NCORNER];

  // hold every stage while the output transaction waits
  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eps_q <= '0;
    end else if (cfg_we_i) begin
      eps_q <= cfg_wdata_i;
    end
  end

  assign tri_in[0] = {corner_a_z_i, corner_a_y_i, corner_a_x_i};
  assign tri_in[1] = {corner_b_z_i, corner_b_y_i, corner_b_x_i};
  assign tri_in[2] = {corner_c_z_i, corner_c_y_i, corner_c_x_i};

  cotw_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .tri_i   (tri_in),
    .valid_o (fr_valid),
    .s_o     (fr_s),
    .dots_o  (fr_dots)
  );

  cotw_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (fr_valid),
    .s_i     (fr_s),
    .side_i  (fr_dots),
    .valid_o (sq_valid),
    .root_o  (sq_root),
    .side_o  (sq_dots)
  );

  // denominator: rounded-down norm plus epsilon
  assign qs_q_d = Q_W'(sq_root) + (Q_W'(eps_q) << EPS_SH);

  always_ff @(posedge clk_i) begin
    if (en) begin
      qs_q_q     <= qs_q_d;
      qs_qzero_q <= (qs_q_d == '0);
      qs_dots_q  <= sq_dots;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qs_valid_q <= 1'b0;
    end else if (en) begin
      qs_valid_q <= sq_valid;
    end
  end

  for (genvar k = 0; k < NCORNER; k++) begin : g_corner
    cotw_div u_div (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (qs_valid_q),
      .dot_i   (qs_dots_q[k]),
      .q_i     (qs_q_q),
      .qzero_i (qs_qzero_q),
      .res_o   (dv[k])
    );
  end

  // clamp and apply sign
  always_comb begin
    logic [QUO_W-1:0] lim;
    logic [QUO_W-1:0] mag;
    sat_d = 1'b0;
    for (int k = 0; k < NCORNER; k++) begin
      lim = dv[k].neg ? LimNeg : LimPos;
      if (dv[k].qzero) begin
        sat_d = 1'b1;
        mag   = dv[k].dzero ? '0 : lim;
      end else if (dv[k].ovf || dv[k].quo > lim) begin
        sat_d = 1'b1;
        mag   = lim;
      end else begin
        mag   = dv[k].quo;
      end
      w_d[k] = dv[k].neg ? -mag[WEIGHT_BITS-1:0] : mag[WEIGHT_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      w_q   <= w_d;
      sat_q <= sat_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= dv[0].valid;
    end
  end

  assign out_valid_o = out_valid_q;
  assign weight_a_o  = w_q[0];
  assign weight_b_o  = w_q[1];
  assign weight_c_o  = w_q[2];
  assign saturated_o = sat_q;

  `COTW_ASSERT_IMPL(a_stall_blocks_input, out_valid_o && !out_ready_i, !in_ready_o, "input accepted while output stalled")
  `COTW_ASSERT_IMPL(a_ready_low_only_on_stall, !in_ready_o, out_valid_o && !out_ready_i, "pipeline held without an output stall")
  `COTW_ASSERT_IMPL(a_sat_at_bound, out_valid_o && saturated_o, weight_a_o == WMax || weight_a_o == WMin || weight_a_o == '0 || weight_b_o == WMax || weight_b_o == WMin || weight_b_o == '0 || weight_c_o == WMax || weight_c_o == WMin || weight_c_o == '0, "saturation flag without a clamped weight")

endmodule
`default_nettype wire
